// ----- sv/lrmt_pkg.sv -----
// Shared types and constants for the lazy range-add / range-min tree unit.
`timescale 1ns / 1ps
package lrmt_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int KIND_W  = 2;

  localparam logic [DATA_W-1:0] TOP_VALUE = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BUILD,
    OP_ADD,
    OP_QUERY
  } op_e;

  // read address select for the node stores
  typedef enum logic [1:0] {
    AS_NODE,
    AS_LEFT,
    AS_RIGHT
  } asel_e;

  // tree-minimum write source
  typedef enum logic [1:0] {
    TW_PUSH,
    TW_MIN,
    TW_ELEM,
    TW_CLR
  } tw_e;

  // pending-add write source
  typedef enum logic [1:0] {
    PW_PUSH,
    PW_LEFT,
    PW_RIGHT,
    PW_CLR
  } pw_e;

  typedef enum logic [3:0] {
    S_RCLR,
    S_IDLE,
    S_BCLR,
    S_ENTER,
    S_PUSH,
    S_CL,
    S_CR,
    S_DOWN,
    S_LEAFW,
    S_RET,
    S_RC0,
    S_RC1,
    S_RC2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic  take;
    logic  root;
    logic  clr_step;
    logic  descend;
    logic  sib;
    logic  up;
    logic  push;
    logic  lat_left;
    logic  emit;
    logic  tree_we;
    tw_e   tw_sel;
    logic  pend_we;
    pw_e   pw_sel;
    asel_e ta_sel;
    asel_e pa_sel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic leaf;
    logic disjoint;
    logic full;
    logic top_level;
    logic is_left;
    logic add_nz;
    logic clr_done;
    logic out_free;
  } st_t;

endpackage

// ----- sv/lrmt_req_if.sv -----
// Request channel interface: valid/ready plus the operation payload.
`timescale 1ns / 1ps
interface lrmt_req_if;
  logic                               valid;
  logic                               ready;
  logic [lrmt_pkg::KIND_W-1:0]        kind;
  logic [lrmt_pkg::INDEX_W-1:0]       low_index;
  logic [lrmt_pkg::INDEX_W-1:0]       high_index;
  logic signed [lrmt_pkg::DATA_W-1:0] value;

  modport source (output valid, kind, low_index, high_index, value, input ready);
  modport sink (input valid, kind, low_index, high_index, value, output ready);
endinterface

// ----- sv/lrmt_rsp_if.sv -----
// Result channel interface: valid/ready plus the range minimum.
`timescale 1ns / 1ps
interface lrmt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [lrmt_pkg::DATA_W-1:0] minimum;

  modport source (output valid, minimum, input ready);
  modport sink (input valid, minimum, output ready);
endinterface

// ----- sv/lazy_range_add_min_tree_unit.sv -----
// Top level of the lazy range-add / range-minimum segment tree unit.
//
//  channel   dir  handshake          payload
//  req_i     in   valid/ready        kind, low_index, high_index, value
//  rsp_o     out  valid/ready        minimum (one per range-min request)
//  cfg       in   cfg_we_i           cfg_data_i = element_count
//
// A load is one element-store write. A range add or range-min walks the tree
// one node at a time through node RAMs with one read and one write port: each
// node visit has enter, push and return steps, with CL and CR when a pending
// add moves to the children, a descend step per split, and RC0-RC2 to rebuild
// a parent minimum (adds and builds).
// Build sweeps 2*2^ceil(log2 MaxElements) node entries, then walks the tree, writing each leaf.
// After reset the same sweep clears both node stores; no request is taken
// until it ends. A waiting result stalls only the next range-min completion.
`timescale 1ns / 1ps
module lazy_range_add_min_tree_unit #(
  parameter int MaxElements = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lrmt_req_if.sink                      req_i,
  lrmt_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [lrmt_pkg::COUNT_W-1:0]  cfg_data_i
);
  lrmt_pkg::cmd_t cmd;
  lrmt_pkg::st_t  st;
  lrmt_pkg::op_e  req_kind;

  assign req_kind = lrmt_pkg::op_e'(req_i.kind);

  // sequencer: clear sweeps, node visits, descend/return steps
  lrmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_kind_i (req_kind),
    .st_i       (st),
    .req_ready_o(req_i.ready),
    .cmd_o      (cmd)
  );

  // node stores, walk registers, result register
  lrmt_dp #(.MaxElements(MaxElements)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_kind_i (req_kind),
    .req_low_i  (req_i.low_index),
    .req_high_i (req_i.high_index),
    .req_value_i(req_i.value),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .rsp_min_o  (rsp_o.minimum)
  );

  // at most one walk move per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.descend, cmd.sib, cmd.up}))
    else $error("conflicting walk moves");

  // a leaf never splits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.descend |-> !st.leaf)
    else $error("descend below a leaf");

  // a result appears only after the sequencer hands it over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.emit))
    else $error("result without emit");

  // the walk is at the root again whenever a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> st.top_level)
    else $error("request taken mid-walk");
endmodule

// ----- sv/lrmt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lrmt_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- sv/lrmt_ctrl.sv -----
// Sequencer for clear sweeps and the explicit tree walk.
`timescale 1ns / 1ps
module lrmt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  lrmt_pkg::op_e    req_kind_i,
  input  lrmt_pkg::st_t    st_i,
  output logic             req_ready_o,
  output lrmt_pkg::cmd_t   cmd_o
);
  lrmt_pkg::state_e state_q, state_d;
  logic             stop_here;

  // after the push-down a node either ends its visit or splits
  assign stop_here = st_i.disjoint | st_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrmt_pkg::S_RCLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrmt_pkg::S_RCLR: begin
        if (st_i.clr_done) state_d = lrmt_pkg::S_IDLE;
      end
      lrmt_pkg::S_IDLE: begin
        if (req_valid_i) begin
          case (req_kind_i)
            lrmt_pkg::OP_LOAD:  state_d = lrmt_pkg::S_IDLE;
            lrmt_pkg::OP_BUILD: state_d = lrmt_pkg::S_BCLR;
            default:            state_d = lrmt_pkg::S_ENTER;
          endcase
        end
      end
      lrmt_pkg::S_BCLR: begin
        if (st_i.clr_done) state_d = lrmt_pkg::S_ENTER;
      end
      lrmt_pkg::S_ENTER: begin
        if (st_i.op == lrmt_pkg::OP_BUILD) begin
          state_d = st_i.leaf ? lrmt_pkg::S_LEAFW : lrmt_pkg::S_DOWN;
        end else begin
          state_d = lrmt_pkg::S_PUSH;
        end
      end
      lrmt_pkg::S_PUSH: begin
        if (!st_i.leaf && st_i.add_nz) state_d = lrmt_pkg::S_CL;
        else state_d = stop_here ? lrmt_pkg::S_RET : lrmt_pkg::S_DOWN;
      end
      lrmt_pkg::S_CL: state_d = lrmt_pkg::S_CR;
      lrmt_pkg::S_CR: state_d = stop_here ? lrmt_pkg::S_RET : lrmt_pkg::S_DOWN;
      lrmt_pkg::S_DOWN: state_d = lrmt_pkg::S_ENTER;
      lrmt_pkg::S_LEAFW: state_d = lrmt_pkg::S_RET;
      lrmt_pkg::S_RET: begin
        if (st_i.top_level) begin
          state_d = (st_i.op == lrmt_pkg::OP_QUERY) ? lrmt_pkg::S_OUT : lrmt_pkg::S_IDLE;
        end else if (st_i.is_left) begin
          state_d = lrmt_pkg::S_ENTER;
        end else begin
          state_d = (st_i.op == lrmt_pkg::OP_QUERY) ? lrmt_pkg::S_RET : lrmt_pkg::S_RC0;
        end
      end
      lrmt_pkg::S_RC0: state_d = lrmt_pkg::S_RC1;
      lrmt_pkg::S_RC1: state_d = lrmt_pkg::S_RC2;
      lrmt_pkg::S_RC2: state_d = lrmt_pkg::S_RET;
      lrmt_pkg::S_OUT: begin
        if (st_i.out_free) state_d = lrmt_pkg::S_IDLE;
      end
      default: state_d = lrmt_pkg::S_RCLR;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.ta_sel = lrmt_pkg::AS_NODE;
    cmd_o.pa_sel = lrmt_pkg::AS_NODE;
    cmd_o.tw_sel = lrmt_pkg::TW_CLR;
    cmd_o.pw_sel = lrmt_pkg::PW_CLR;
    req_ready_o  = 1'b0;
    case (state_q)
      lrmt_pkg::S_RCLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.tree_we  = 1'b1;
        cmd_o.pend_we  = 1'b1;
      end
      lrmt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
      end
      lrmt_pkg::S_BCLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.tree_we  = 1'b1;
        cmd_o.pend_we  = 1'b1;
        cmd_o.root     = st_i.clr_done;
      end
      lrmt_pkg::S_PUSH: begin
        cmd_o.push    = 1'b1;
        cmd_o.tree_we = 1'b1;
        cmd_o.tw_sel  = lrmt_pkg::TW_PUSH;
        cmd_o.pend_we = 1'b1;
        cmd_o.pw_sel  = lrmt_pkg::PW_PUSH;
        cmd_o.pa_sel  = lrmt_pkg::AS_LEFT;
      end
      lrmt_pkg::S_CL: begin
        cmd_o.pend_we = 1'b1;
        cmd_o.pw_sel  = lrmt_pkg::PW_LEFT;
        cmd_o.pa_sel  = lrmt_pkg::AS_RIGHT;
      end
      lrmt_pkg::S_CR: begin
        cmd_o.pend_we = 1'b1;
        cmd_o.pw_sel  = lrmt_pkg::PW_RIGHT;
      end
      lrmt_pkg::S_DOWN: cmd_o.descend = 1'b1;
      lrmt_pkg::S_LEAFW: begin
        cmd_o.tree_we = 1'b1;
        cmd_o.tw_sel  = lrmt_pkg::TW_ELEM;
      end
      lrmt_pkg::S_RET: begin
        if (!st_i.top_level) begin
          cmd_o.sib = st_i.is_left;
          cmd_o.up  = !st_i.is_left;
        end
      end
      lrmt_pkg::S_RC0: cmd_o.ta_sel = lrmt_pkg::AS_LEFT;
      lrmt_pkg::S_RC1: begin
        cmd_o.ta_sel   = lrmt_pkg::AS_RIGHT;
        cmd_o.lat_left = 1'b1;
      end
      lrmt_pkg::S_RC2: begin
        cmd_o.tree_we = 1'b1;
        cmd_o.tw_sel  = lrmt_pkg::TW_MIN;
      end
      lrmt_pkg::S_OUT: cmd_o.emit = st_i.out_free;
      default: cmd_o.take = 1'b0;
    endcase
  end
endmodule

// ----- sv/lrmt_dp.sv -----
// Datapath: node stores, element store, walk registers and result register.
`timescale 1ns / 1ps
module lrmt_dp #(
  parameter int MaxElements = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrmt_pkg::cmd_t                      cmd_i,
  output lrmt_pkg::st_t                       st_o,
  input  logic                                cfg_we_i,
  input  logic [lrmt_pkg::COUNT_W-1:0]        cfg_data_i,
  input  lrmt_pkg::op_e                       req_kind_i,
  input  logic [lrmt_pkg::INDEX_W-1:0]        req_low_i,
  input  logic [lrmt_pkg::INDEX_W-1:0]        req_high_i,
  input  logic signed [lrmt_pkg::DATA_W-1:0]  req_value_i,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output logic signed [lrmt_pkg::DATA_W-1:0]  rsp_min_o
);
  localparam int IdxW      = $clog2(MaxElements);
  localparam int XW        = (IdxW > lrmt_pkg::INDEX_W) ? IdxW : lrmt_pkg::INDEX_W;
  localparam int NW        = IdxW + 1;
  localparam int TreeDepth = 2 ** NW;
  localparam int StkN      = IdxW + 1;
  localparam int DW        = $clog2(StkN);
  localparam int DataW     = lrmt_pkg::DATA_W;

  logic [lrmt_pkg::COUNT_W-1:0] cnt_q;
  lrmt_pkg::op_e                op_q;
  logic [XW-1:0]                ql_q, qh_q, lo_q, hi_q;
  logic [DataW-1:0]             val_q, acc_q, add_q, left_q, out_min_q;
  logic [NW-1:0]                node_q, clr_q;
  logic [DW-1:0]                depth_q;
  logic [XW-1:0]                stk_lo_q [StkN];
  logic [XW-1:0]                stk_hi_q [StkN];
  logic                         out_valid_q;

  logic [16:0]      cnt_ext;
  logic [XW-1:0]    top_idx, mid;
  logic [XW:0]      lohi_sum;
  logic [NW-1:0]    left_node, right_node, node_m1, parent_node;
  logic [DW-1:0]    depth_m1;
  logic             full, root_init;
  logic [DataW-1:0] tree_rd, pend_rd, elem_rd, push_add, push_min, rc_min, acc_min;
  logic [NW-1:0]    t_raddr, p_raddr, t_waddr, p_waddr;
  logic [DataW-1:0] t_wdata, p_wdata;
  logic             elem_we;

  // count clamp: zero means one, above capacity means capacity
  always_comb begin
    cnt_ext = 17'(cnt_q);
    if (cnt_ext == 17'd0) top_idx = '0;
    else if (cnt_ext > 17'(MaxElements)) top_idx = XW'(MaxElements - 1);
    else top_idx = XW'(cnt_ext - 17'd1);
  end

  assign lohi_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid         = lohi_sum[XW:1];
  assign left_node   = {node_q[NW-2:0], 1'b1};
  assign right_node  = left_node + 1'b1;
  assign node_m1     = node_q - 1'b1;
  assign parent_node = {1'b0, node_m1[NW-1:1]};
  assign depth_m1    = depth_q - 1'b1;
  assign full        = (ql_q <= lo_q) && (qh_q >= hi_q);
  assign root_init   = cmd_i.take | cmd_i.root;

  // pushed add plus, for a covered node of a range add, the new amount
  assign push_add = pend_rd + (((op_q == lrmt_pkg::OP_ADD) && full) ? val_q : '0);
  assign push_min = tree_rd + push_add;
  assign rc_min   = ($signed(left_q) < $signed(tree_rd)) ? left_q : tree_rd;
  assign acc_min  = ($signed(push_min) < $signed(acc_q)) ? push_min : acc_q;

  always_comb begin
    case (cmd_i.ta_sel)
      lrmt_pkg::AS_LEFT:  t_raddr = left_node;
      lrmt_pkg::AS_RIGHT: t_raddr = right_node;
      default:            t_raddr = node_q;
    endcase
    case (cmd_i.pa_sel)
      lrmt_pkg::AS_LEFT:  p_raddr = left_node;
      lrmt_pkg::AS_RIGHT: p_raddr = right_node;
      default:            p_raddr = node_q;
    endcase
    case (cmd_i.tw_sel)
      lrmt_pkg::TW_PUSH: begin t_waddr = node_q; t_wdata = push_min; end
      lrmt_pkg::TW_MIN:  begin t_waddr = node_q; t_wdata = rc_min;   end
      lrmt_pkg::TW_ELEM: begin t_waddr = node_q; t_wdata = elem_rd;  end
      default:           begin t_waddr = clr_q;  t_wdata = lrmt_pkg::TOP_VALUE; end
    endcase
    case (cmd_i.pw_sel)
      lrmt_pkg::PW_PUSH:  begin p_waddr = node_q;     p_wdata = '0; end
      lrmt_pkg::PW_LEFT:  begin p_waddr = left_node;  p_wdata = pend_rd + add_q; end
      lrmt_pkg::PW_RIGHT: begin p_waddr = right_node; p_wdata = pend_rd + add_q; end
      default:            begin p_waddr = clr_q;      p_wdata = '0; end
    endcase
  end

  assign elem_we = cmd_i.take && (req_kind_i == lrmt_pkg::OP_LOAD)
                   && (32'(req_low_i) < MaxElements);

  lrmt_ram #(.Width(DataW), .Depth(TreeDepth)) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.tree_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .raddr_i(t_raddr),
    .rdata_o(tree_rd)
  );

  lrmt_ram #(.Width(DataW), .Depth(TreeDepth)) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.pend_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(pend_rd)
  );

  lrmt_ram #(.Width(DataW), .Depth(MaxElements)) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (elem_we),
    .waddr_i(IdxW'(req_low_i)),
    .wdata_i(req_value_i),
    .raddr_i(lo_q[IdxW-1:0]),
    .rdata_o(elem_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= lrmt_pkg::COUNT_W'(1);
      op_q        <= lrmt_pkg::OP_LOAD;
      node_q      <= '0;
      depth_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cnt_q <= cfg_data_i;
      if (cmd_i.take) op_q <= req_kind_i;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (root_init) begin
        node_q  <= '0;
        depth_q <= '0;
      end else if (cmd_i.descend) begin
        node_q  <= left_node;
        depth_q <= depth_q + 1'b1;
      end else if (cmd_i.sib) begin
        node_q  <= node_q + 1'b1;
      end else if (cmd_i.up) begin
        node_q  <= parent_node;
        depth_q <= depth_m1;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (rsp_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      ql_q  <= XW'(req_low_i);
      qh_q  <= XW'(req_high_i);
      val_q <= req_value_i;
      acc_q <= lrmt_pkg::TOP_VALUE;
    end
    if (root_init) begin
      lo_q <= '0;
      hi_q <= top_idx;
    end else if (cmd_i.descend) begin
      stk_lo_q[depth_q] <= lo_q;
      stk_hi_q[depth_q] <= hi_q;
      hi_q              <= mid;
    end else if (cmd_i.sib) begin
      lo_q <= hi_q + 1'b1;
      hi_q <= stk_hi_q[depth_m1];
    end else if (cmd_i.up) begin
      lo_q <= stk_lo_q[depth_m1];
      hi_q <= stk_hi_q[depth_m1];
    end
    if (cmd_i.push) begin
      add_q <= push_add;
      if ((op_q == lrmt_pkg::OP_QUERY) && full) acc_q <= acc_min;
    end
    if (cmd_i.lat_left) left_q <= tree_rd;
    if (cmd_i.emit) out_min_q <= acc_q;
  end

  assign st_o.op        = op_q;
  assign st_o.leaf      = (lo_q == hi_q);
  assign st_o.disjoint  = (lo_q > qh_q) || (hi_q < ql_q);
  assign st_o.full      = full;
  assign st_o.top_level = (depth_q == '0);
  assign st_o.is_left   = node_q[0];
  assign st_o.add_nz    = (push_add != '0);
  assign st_o.clr_done  = &clr_q;
  assign st_o.out_free  = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign rsp_min_o   = out_min_q;
endmodule

// ----- tb/lrmt_tb_pkg.sv -----
// Testbench-side constants used by the checker.
`timescale 1ns / 1ps
package lrmt_tb_pkg;
  localparam int unsigned NODE_CAP = 4096;
  localparam int unsigned MAX_ELEMS = 1024;
endpackage

// ----- tb/lrmt_tree_checker.sv -----
// Checker: watches the request and result channels, predicts minima, compares.
`timescale 1ns / 1ps
module lrmt_tree_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  lrmt_req_if.sink         req_mon,
  lrmt_rsp_if.sink         rsp_mon,
  input  logic             cfg_we_i,
  input  logic [10:0]      cfg_data_i,
  output int               errors_o,
  output int               pending_o
);
  import lrmt_pkg::*;
  import lrmt_tb_pkg::*;

  logic [31:0] elems [MAX_ELEMS];
  logic [31:0] tmin [NODE_CAP];
  logic [31:0] tadd [NODE_CAP];
  logic [10:0] count_reg;
  logic [31:0] minima_q [$];

  function automatic logic [31:0] smin(logic [31:0] a, logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [31:0] nmin(int unsigned n);
    return n < NODE_CAP ? tmin[n] : TOP_VALUE;
  endfunction

  function automatic void wipe();
    for (int i = 0; i < NODE_CAP; i++) begin
      tmin[i] = TOP_VALUE;
      tadd[i] = '0;
    end
  endfunction

  function automatic void settle(int unsigned n, int unsigned lo, int unsigned hi);
    logic [31:0] p;
    p = tadd[n];
    if (p != 0) begin
      tmin[n] += p;
      if (lo != hi) begin
        if (2*n+1 < NODE_CAP) tadd[2*n+1] += p;
        if (2*n+2 < NODE_CAP) tadd[2*n+2] += p;
      end
      tadd[n] = '0;
    end
  endfunction

  function automatic void grow(int unsigned n, int unsigned lo, int unsigned hi);
    int unsigned mid;
    if (n >= NODE_CAP) return;
    if (lo == hi) begin
      tmin[n] = elems[lo];
      return;
    end
    mid = (lo + hi) >> 1;
    grow(2*n+1, lo, mid);
    grow(2*n+2, mid+1, hi);
    tmin[n] = smin(nmin(2*n+1), nmin(2*n+2));
  endfunction

  function automatic logic [31:0] span_min(int unsigned n, int unsigned lo,
      int unsigned hi, int unsigned ql, int unsigned qh);
    int unsigned mid;
    if (n >= NODE_CAP) return TOP_VALUE;
    settle(n, lo, hi);
    if (lo > qh || hi < ql) return TOP_VALUE;
    if (lo >= ql && hi <= qh) return tmin[n];
    mid = (lo + hi) >> 1;
    return smin(span_min(2*n+1, lo, mid, ql, qh), span_min(2*n+2, mid+1, hi, ql, qh));
  endfunction

  function automatic void span_add(int unsigned n, int unsigned lo, int unsigned hi,
      int unsigned ql, int unsigned qh, logic [31:0] d);
    int unsigned mid;
    if (n >= NODE_CAP || lo > hi) return;
    settle(n, lo, hi);
    if (hi < ql || lo > qh) return;
    if (ql <= lo && qh >= hi) begin
      tmin[n] += d;
      if (lo != hi) begin
        if (2*n+1 < NODE_CAP) tadd[2*n+1] += d;
        if (2*n+2 < NODE_CAP) tadd[2*n+2] += d;
      end
      return;
    end
    mid = (lo + hi) >> 1;
    span_add(2*n+1, lo, mid, ql, qh, d);
    span_add(2*n+2, mid+1, hi, ql, qh, d);
    tmin[n] = smin(nmin(2*n+1), nmin(2*n+2));
  endfunction

  function automatic int unsigned top_index();
    int unsigned c;
    c = count_reg;
    if (c == 0) c = 1;
    if (c > MAX_ELEMS) c = MAX_ELEMS;
    return c - 1;
  endfunction

  assign pending_o = minima_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      wipe();
      count_reg <= 11'd1;
      minima_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i) count_reg <= cfg_data_i;
      if (req_mon.valid && req_mon.ready) begin
        case (op_e'(req_mon.kind))
          OP_LOAD:  elems[req_mon.low_index] = req_mon.value;
          OP_BUILD: begin
            wipe();
            grow(0, 0, top_index());
          end
          OP_ADD:   span_add(0, 0, top_index(), req_mon.low_index, req_mon.high_index,
                             req_mon.value);
          default:  minima_q.push_back(span_min(0, 0, top_index(), req_mon.low_index,
                                                req_mon.high_index));
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (minima_q.size() == 0) begin
          $display("%0t: unexpected minimum, expected none, got %0d", $time,
                   rsp_mon.minimum);
          errors_o <= errors_o + 1;
        end else begin
          want = minima_q.pop_front();
          if (rsp_mon.minimum !== want) begin
            $display("%0t: minimum mismatch, expected %0d, got %0d", $time,
                     $signed(want), rsp_mon.minimum);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/lazy_range_add_min_tree_unit_test.sv -----
// Stimulus top: drives requests and config, sets result backpressure, gives verdict.
`timescale 1ns / 1ps
module lazy_range_add_min_tree_unit_test;
  import lrmt_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_data_i = 11'd1;
  int          errors;
  int          outstanding;
  int          idle_pct = 22;   // 0 during the no-gap stretch
  bit          hold_rsp = 1'b0; // long result hold-off, to back the unit up
  bit          done = 1'b0;
  int          quiet_cycles = 0;
  int          live_count = 1;  // count the stimulus is shaped for

  lrmt_req_if req_ch ();
  lrmt_rsp_if rsp_ch ();

  lazy_range_add_min_tree_unit uut (
    .clk_i, .rst_ni, .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .cfg_we_i, .cfg_data_i
  );

  lrmt_tree_checker chk (
    .clk_i, .rst_ni, .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .cfg_we_i, .cfg_data_i, .errors_o(errors), .pending_o(outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.low_index = '0;
    req_ch.high_index = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  // result-side ready: random stalls unless a hold-off is in force
  always @(posedge clk_i) begin
    if (!rst_ni || hold_rsp) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT && !done) begin
      $display("[lazy_range_add_min_tree_unit] ERROR");
      $finish;
    end
  end

  // One request: optional random gap with valid low, then hold valid until accepted.
  task automatic send(op_e op, int lo, int hi, logic [31:0] val);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= op;
    req_ch.low_index <= lo[9:0];
    req_ch.high_index <= hi[9:0];
    req_ch.value <= val;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Wait for all minima, then let any trailing add/build finish before a write.
  task automatic set_count(int c);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= c[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    live_count = (c == 0) ? 1 : (c > 1024 ? 1024 : c);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Load every covered element, then build.
  task automatic fill_and_build();
    for (int i = 0; i < live_count; i++) send(OP_LOAD, i, $urandom, rnd_val());
    send(OP_BUILD, $urandom, $urandom, $urandom);
  endtask

  // Random mix of adds, queries, loads and (on small counts) rebuilds; indices mostly inside the live range.
  task automatic random_ops(int n);
    int lo, hi, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if ($urandom_range(9) == 0) begin
        lo = $urandom_range(1023);
        hi = $urandom_range(1023);
      end else begin
        lo = $urandom_range(live_count - 1);
        hi = $urandom_range(lo, live_count - 1);
      end
      if (k < 4) send(OP_ADD, lo, hi, rnd_val());
      else if (k < 9) send(OP_QUERY, lo, hi, $urandom);
      else if (k == 9 && live_count <= 64) fill_and_build();
      else send(OP_LOAD, $urandom_range(live_count - 1), $urandom, rnd_val());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: queries on the cleared tree, then small trees and corner ranges
    send(OP_QUERY, 0, 0, '0);
    send(OP_ADD, 0, 1023, 32'd5);
    send(OP_QUERY, 0, 1023, '0);
    set_count(0);
    send(OP_LOAD, 0, 0, 32'h8000_0000);
    send(OP_BUILD, 0, 0, '0);
    send(OP_QUERY, 0, 0, '0);
    set_count(8);
    for (int i = 0; i < 8; i++) send(OP_LOAD, i, 1023, (i == 3) ? 32'h7FFF_FFFF : i * 3 - 7);
    send(OP_LOAD, 1023, 0, 32'd99);
    send(OP_BUILD, 1023, 1023, 32'hFFFF_FFFF);
    send(OP_QUERY, 0, 7, '0);
    send(OP_ADD, 2, 5, 32'h7FFF_FFFF);   // wraps
    send(OP_QUERY, 3, 3, '0);
    send(OP_ADD, 6, 2, 32'd1);           // low above high
    send(OP_QUERY, 5, 1, '0);
    send(OP_ADD, 8, 1023, 32'd1);        // beyond count
    send(OP_QUERY, 8, 1023, '0);
    send(OP_QUERY, 4, 1023, '0);         // partly beyond count
    send(OP_ADD, 0, 7, 32'h8000_0000);
    send(OP_QUERY, 1, 6, '0);

    // random phases over several counts, extremes included
    set_count(13);
    fill_and_build();
    random_ops(150);
    set_count(1);
    fill_and_build();
    random_ops(40);

    // no-gap stretch, then a long result hold-off so requests back up
    set_count(37);
    fill_and_build();
    idle_pct = 0;
    random_ops(40);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 30; i++) send(OP_QUERY, 0, $urandom_range(36), '0);
    join
    idle_pct = 22;
    random_ops(40);

    set_count(2047);                    // used as 1024; walks the tree as it stands
    random_ops(60);
    set_count(5);
    fill_and_build();
    random_ops(140);

    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
    done = 1'b1;
    if (errors == 0) begin
      $display("[lazy_range_add_min_tree_unit] OK");
    end else begin
      $display("[lazy_range_add_min_tree_unit] ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/lrmt_pkg.sv
sv/lrmt_req_if.sv
sv/lrmt_rsp_if.sv
sv/lrmt_ram.sv
sv/lrmt_ctrl.sv
sv/lrmt_dp.sv
sv/lazy_range_add_min_tree_unit.sv
tb/lrmt_tb_pkg.sv
tb/lrmt_tree_checker.sv
tb/lazy_range_add_min_tree_unit_test.sv
